// File: src/pse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants of the postfix stack evaluator: character codes,
// status codes, operator codes and the control and status structs of the arithmetic unit.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_VALUE_BITS  = 48;

    localparam int SYMBOL_W = 8;
    localparam int LIMIT_W  = 5;
    localparam int DEPTH_W  = 5;
    localparam int STATUS_W = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd8;

    localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_PUSH_FULL    = 3'd1,
        ST_MISSING      = 3'd2,
        ST_DIV_ZERO     = 3'd3,
        ST_SATURATED    = 3'd4,
        ST_FINISH_EMPTY = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_ctl;

    typedef struct packed {
        logic done;
        logic sat;
        logic div_zero;
    } t_alu_sts;

endpackage
`default_nettype wire

// File: src/pse_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pse_alu
// Shared arithmetic unit: one adder/subtractor serves add, subtract, operand
// magnitudes, shift-add multiply, restoring divide and the final sign fix.
// ----------------------------------------------------------------------------
module pse_alu #(
    parameter int VALUE_BITS = pse_pkg::DEF_VALUE_BITS,
    parameter int FRAC_BITS  = pse_pkg::DEF_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire pse_pkg::t_alu_ctl     i_ctl,
    input  wire logic [VALUE_BITS-1:0] i_a,
    input  wire logic [VALUE_BITS-1:0] i_b,
    output pse_pkg::t_alu_sts          o_sts,
    output logic      [VALUE_BITS-1:0] o_result
);
    import pse_pkg::*;

    localparam int VB     = VALUE_BITS;
    localparam int AW     = VB + 2;
    localparam int SH_W   = VB + FRAC_BITS;
    localparam int WIDE_W = 2 * VB + FRAC_BITS;
    localparam int CNT_W  = $clog2(SH_W + 1);

    localparam logic [VB-1:0] SMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic [VB-1:0] SMIN = {1'b1, {(VB-1){1'b0}}};

    typedef enum logic [2:0] {
        A_IDLE,
        A_ADDSUB,
        A_MAG_A,
        A_MAG_B,
        A_MUL,
        A_DIV,
        A_FIX
    } t_alu_state;

    t_alu_state        r_state, n_state;
    t_op               r_op, n_op;
    logic [VB-1:0]     r_a, n_a;
    logic [VB-1:0]     r_b, n_b;
    logic              r_neg, n_neg;
    logic [VB-1:0]     r_x, n_x;
    logic [VB-1:0]     r_y, n_y;
    logic [VB-1:0]     r_acc, n_acc;
    logic [SH_W-1:0]   r_sh, n_sh;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [VB-1:0]     r_res, n_res;
    logic              r_done, n_done;
    logic              r_sat, n_sat;
    logic              r_dz, n_dz;

    logic [AW-1:0]     add_x, add_y, add_y_eff, add_sum;
    logic              add_sub;
    logic [WIDE_W-1:0] mag_wide;
    logic [VB-1:0]     mag_lo, mag_lim;
    logic              mag_sat, fits;
    logic              div_ge;

    // shared adder
    assign add_y_eff = add_sub ? ~add_y : add_y;
    assign add_sum   = add_x + add_y_eff + {{(AW-1){1'b0}}, add_sub};

    // magnitude of the raw product or quotient and its saturation check
    always_comb begin
        if (r_op == OP_MUL) begin
            mag_wide = WIDE_W'({r_acc, r_sh[VB-1:0]}) >> FRAC_BITS;
        end else begin
            mag_wide = WIDE_W'(r_sh);
        end
        mag_lo  = mag_wide[VB-1:0];
        mag_lim = r_neg ? SMIN : SMAX;
        mag_sat = (|mag_wide[WIDE_W-1:VB]) || (mag_lo > mag_lim);
    end

    assign fits   = (&add_sum[AW-1:VB-1]) || !(|add_sum[AW-1:VB-1]);
    assign div_ge = !add_sum[AW-1];

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_a     = r_a;
        n_b     = r_b;
        n_neg   = r_neg;
        n_x     = r_x;
        n_y     = r_y;
        n_acc   = r_acc;
        n_sh    = r_sh;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_done  = 1'b0;
        n_sat   = r_sat;
        n_dz    = r_dz;
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;

        unique case (r_state)
            A_IDLE: begin
                if (i_ctl.start) begin
                    n_op    = i_ctl.op;
                    n_a     = i_a;
                    n_b     = i_b;
                    n_neg   = i_a[VB-1] ^ i_b[VB-1];
                    n_state = (i_ctl.op == OP_ADD || i_ctl.op == OP_SUB) ? A_ADDSUB : A_MAG_A;
                end
            end
            A_ADDSUB: begin
                add_x   = {{2{r_a[VB-1]}}, r_a};
                add_y   = {{2{r_b[VB-1]}}, r_b};
                add_sub = (r_op == OP_SUB);
                n_res   = fits ? add_sum[VB-1:0] : (add_sum[AW-1] ? SMIN : SMAX);
                n_sat   = !fits;
                n_dz    = 1'b0;
                n_done  = 1'b1;
                n_state = A_IDLE;
            end
            A_MAG_A: begin
                add_x   = r_a[VB-1] ? '0 : {{2{r_a[VB-1]}}, r_a};
                add_y   = r_a[VB-1] ? {{2{r_a[VB-1]}}, r_a} : '0;
                add_sub = r_a[VB-1];
                n_x     = add_sum[VB-1:0];
                n_state = A_MAG_B;
            end
            A_MAG_B: begin
                add_x   = r_b[VB-1] ? '0 : {{2{r_b[VB-1]}}, r_b};
                add_y   = r_b[VB-1] ? {{2{r_b[VB-1]}}, r_b} : '0;
                add_sub = r_b[VB-1];
                n_y     = add_sum[VB-1:0];
                n_acc   = '0;
                n_cnt   = '0;
                if (r_op == OP_MUL) begin
                    n_sh    = SH_W'(add_sum[VB-1:0]);
                    n_state = A_MUL;
                end else if (!(|r_b)) begin
                    if (r_a[VB-1]) begin
                        n_res = SMIN;
                    end else if (|r_a) begin
                        n_res = SMAX;
                    end else begin
                        n_res = '0;
                    end
                    n_sat   = 1'b0;
                    n_dz    = 1'b1;
                    n_done  = 1'b1;
                    n_state = A_IDLE;
                end else begin
                    n_sh    = SH_W'(r_x) << FRAC_BITS;
                    n_state = A_DIV;
                end
            end
            A_MUL: begin
                add_x            = AW'(r_acc);
                add_y            = r_sh[0] ? AW'(r_x) : '0;
                n_acc            = add_sum[VB:1];
                n_sh[VB-1:0]     = {add_sum[0], r_sh[VB-1:1]};
                n_cnt            = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VB - 1)) begin
                    n_state = A_FIX;
                end
            end
            A_DIV: begin
                add_x   = AW'({r_acc, r_sh[SH_W-1]});
                add_y   = AW'(r_y);
                add_sub = 1'b1;
                n_acc   = div_ge ? add_sum[VB-1:0] : {r_acc[VB-2:0], r_sh[SH_W-1]};
                n_sh    = {r_sh[SH_W-2:0], div_ge};
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SH_W - 1)) begin
                    n_state = A_FIX;
                end
            end
            A_FIX: begin
                add_x   = '0;
                add_y   = AW'(mag_lo);
                add_sub = 1'b1;
                if (mag_sat) begin
                    n_res = mag_lim;
                end else begin
                    n_res = r_neg ? add_sum[VB-1:0] : mag_lo;
                end
                n_sat   = mag_sat;
                n_dz    = 1'b0;
                n_done  = 1'b1;
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_neg <= n_neg;
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
        r_sh  <= n_sh;
        r_cnt <= n_cnt;
        r_res <= n_res;
        r_sat <= n_sat;
        r_dz  <= n_dz;
    end

    assign o_sts.done     = r_done;
    assign o_sts.sat      = r_sat;
    assign o_sts.div_zero = r_dz;
    assign o_result       = r_res;

endmodule
`default_nettype wire

// File: src/postfix_stack_evaluator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core
// Evaluates a postfix expression one character beat at a time over a stack of
// signed fixed-point values, with a shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  input     in   i_valid / o_ready          i_symbol, i_finish
//  result    out  o_valid / i_ready          o_top_value, o_stack_depth,
//                                            o_status, o_answer_valid
//  config    in   i_cfg_valid / o_cfg_ready  i_cfg_data (stack limit)
//
//  one input beat at a time; o_ready is low while a beat is in work
//  multiply and divide run through a one-bit-per-cycle loop of the shared
//  adder, so they take longest
//  the result register lets the next beat enter while a result waits
//  synchronous active-low reset empties the stack, limit resets to 8
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core #(
    parameter int STACK_DEPTH = pse_pkg::DEF_STACK_DEPTH,
    parameter int FRAC_BITS   = pse_pkg::DEF_FRAC_BITS,
    parameter int VALUE_BITS  = pse_pkg::DEF_VALUE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [pse_pkg::SYMBOL_W-1:0]  i_symbol,
    input  wire logic                          i_finish,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [VALUE_BITS-1:0]         o_top_value,
    output logic      [pse_pkg::DEPTH_W-1:0]   o_stack_depth,
    output logic      [pse_pkg::STATUS_W-1:0]  o_status,
    output logic                               o_answer_valid,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pse_pkg::LIMIT_W-1:0]   i_cfg_data
);
    import pse_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int AD_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int DIG_W = VB + FRAC_BITS + 4;

    localparam logic [VB-1:0] SMAX = {1'b0, {(VB-1){1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_A,
        S_ALU_GO,
        S_ALU_WAIT,
        S_FIN_RD,
        S_TOP,
        S_TOP_WAIT,
        S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [SYMBOL_W-1:0] r_sym, n_sym;
    logic                r_fin, n_fin;
    t_op                 r_op, n_op;
    logic [CNT_W-1:0]    r_held, n_held;
    logic [LIMIT_W-1:0]  r_stack_limit, n_stack_limit;
    logic [VB-1:0]       r_b, n_b;
    t_status             r_res_status, n_res_status;
    logic [VB-1:0]       r_res_top, n_res_top;
    logic                r_res_ans, n_res_ans;
    logic                r_out_valid, n_out_valid;
    logic [VB-1:0]       r_out_top, n_out_top;
    logic [DEPTH_W-1:0]  r_out_depth, n_out_depth;
    t_status             r_out_status, n_out_status;
    logic                r_out_ans, n_out_ans;

    logic [VB-1:0]       r_mem [STACK_DEPTH];
    logic [VB-1:0]       r_rd_data;
    logic                mem_rd_en, mem_wr_en;
    logic [AD_W-1:0]     mem_rd_addr, mem_wr_addr;
    logic [VB-1:0]       mem_wr_data;

    logic [CNT_W-1:0]         held_m1, held_m2;
    logic                     full;
    logic                     is_digit, is_oper;
    logic [SYMBOL_W-1:0]      dig_code;
    logic [DIG_W-1:0]         dig_wide;
    logic                     dig_sat;
    logic [VB-1:0]            dig_val;
    logic [CNT_W+DEPTH_W-1:0] depth_ext;

    t_alu_ctl            alu_ctl;
    t_alu_sts            alu_sts;
    logic [VB-1:0]       alu_result;

    pse_alu #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (alu_ctl),
        .i_a      (r_rd_data),
        .i_b      (r_b),
        .o_sts    (alu_sts),
        .o_result (alu_result)
    );

    assign held_m1 = r_held - CNT_W'(1);
    assign held_m2 = r_held - CNT_W'(2);
    assign full    = ({{LIMIT_W{1'b0}}, r_held} >= {{CNT_W{1'b0}}, r_stack_limit})
                     || (r_held == CNT_W'(STACK_DEPTH));

    assign is_digit = (r_sym >= CH_ZERO) && (r_sym <= CH_NINE);
    assign is_oper  = (r_sym == CH_PLUS) || (r_sym == CH_MINUS)
                      || (r_sym == CH_STAR) || (r_sym == CH_SLASH);
    assign dig_code = r_sym - CH_ZERO;
    assign dig_wide = DIG_W'(dig_code[3:0]) << FRAC_BITS;
    assign dig_sat  = |dig_wide[DIG_W-1:VB-1];
    assign dig_val  = dig_sat ? SMAX : dig_wide[VB-1:0];

    assign depth_ext = {{DEPTH_W{1'b0}}, r_held};

    always_comb begin
        n_state       = r_state;
        n_sym         = r_sym;
        n_fin         = r_fin;
        n_op          = r_op;
        n_held        = r_held;
        n_stack_limit = r_stack_limit;
        n_b           = r_b;
        n_res_status  = r_res_status;
        n_res_top     = r_res_top;
        n_res_ans     = r_res_ans;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_top     = r_out_top;
        n_out_depth   = r_out_depth;
        n_out_status  = r_out_status;
        n_out_ans     = r_out_ans;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = held_m1[AD_W-1:0];
        mem_wr_en     = 1'b0;
        mem_wr_addr   = r_held[AD_W-1:0];
        mem_wr_data   = dig_val;
        alu_ctl.start = 1'b0;
        alu_ctl.op    = r_op;

        if (i_cfg_valid) begin
            n_stack_limit = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sym   = i_symbol;
                    n_fin   = i_finish;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_ans    = 1'b0;
                n_res_status = ST_OK;
                if (r_fin) begin
                    if (r_held == '0) begin
                        n_res_status = ST_FINISH_EMPTY;
                        n_res_top    = '0;
                        n_state      = S_OUT;
                    end else begin
                        mem_rd_en = 1'b1;
                        n_state   = S_FIN_RD;
                    end
                end else if (is_digit) begin
                    if (full) begin
                        n_res_status = ST_PUSH_FULL;
                    end else begin
                        mem_wr_en    = 1'b1;
                        n_held       = r_held + CNT_W'(1);
                        n_res_status = dig_sat ? ST_SATURATED : ST_OK;
                    end
                    n_state = S_TOP;
                end else if (is_oper) begin
                    case (r_sym)
                        CH_PLUS:  n_op = OP_ADD;
                        CH_MINUS: n_op = OP_SUB;
                        CH_STAR:  n_op = OP_MUL;
                        default:  n_op = OP_DIV;
                    endcase
                    if (r_held < CNT_W'(2)) begin
                        n_res_status = ST_MISSING;
                        n_state      = S_TOP;
                    end else begin
                        mem_rd_en = 1'b1;
                        n_state   = S_RD_A;
                    end
                end else begin
                    n_state = S_TOP;
                end
            end
            S_RD_A: begin
                n_b         = r_rd_data;
                mem_rd_en   = 1'b1;
                mem_rd_addr = held_m2[AD_W-1:0];
                n_state     = S_ALU_GO;
            end
            S_ALU_GO: begin
                alu_ctl.start = 1'b1;
                n_held        = held_m2;
                n_state       = S_ALU_WAIT;
            end
            S_ALU_WAIT: begin
                if (alu_sts.done) begin
                    mem_wr_data = alu_result;
                    if (full) begin
                        n_res_status = ST_PUSH_FULL;
                    end else begin
                        mem_wr_en = 1'b1;
                        n_held    = r_held + CNT_W'(1);
                        if (alu_sts.div_zero) begin
                            n_res_status = ST_DIV_ZERO;
                        end else if (alu_sts.sat) begin
                            n_res_status = ST_SATURATED;
                        end else begin
                            n_res_status = ST_OK;
                        end
                    end
                    n_state = S_TOP;
                end
            end
            S_FIN_RD: begin
                n_res_top = r_rd_data;
                n_res_ans = 1'b1;
                n_held    = '0;
                n_state   = S_OUT;
            end
            S_TOP: begin
                if (r_held == '0) begin
                    n_res_top = '0;
                    n_state   = S_OUT;
                end else begin
                    mem_rd_en = 1'b1;
                    n_state   = S_TOP_WAIT;
                end
            end
            S_TOP_WAIT: begin
                n_res_top = r_rd_data;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_top    = r_res_top;
                    n_out_depth  = depth_ext[DEPTH_W-1:0];
                    n_out_status = r_res_status;
                    n_out_ans    = r_res_ans;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_held        <= '0;
            r_stack_limit <= LIMIT_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_held        <= n_held;
            r_stack_limit <= n_stack_limit;
            r_out_valid   <= n_out_valid;
        end
        r_sym        <= n_sym;
        r_fin        <= n_fin;
        r_op         <= n_op;
        r_b          <= n_b;
        r_res_status <= n_res_status;
        r_res_top    <= n_res_top;
        r_res_ans    <= n_res_ans;
        r_out_top    <= n_out_top;
        r_out_depth  <= n_out_depth;
        r_out_status <= n_out_status;
        r_out_ans    <= n_out_ans;
    end

    // value stack
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[mem_rd_addr];
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_top_value    = r_out_top;
    assign o_stack_depth  = r_out_depth;
    assign o_status       = r_out_status;
    assign o_answer_valid = r_out_ans;

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for postfix_stack_evaluator_core. Directed and random
// expressions go in one beat at a time, both channels stall at random, and
// every result beat is compared with a shadow evaluator kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
    import pse_pkg::*;

    localparam int VW           = DEF_VALUE_BITS;
    localparam int FB           = DEF_FRAC_BITS;
    localparam int DEPTH        = DEF_STACK_DEPTH;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 120;
    localparam int RANDOM_ITEMS = 1100;
    localparam int PHASES       = 10;

    localparam longint VAL_MAX = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [VW-1:0]      top;
        logic [DEPTH_W-1:0] depth;
        t_status            status;
        logic               answer;
    } t_outcome;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic [SYMBOL_W-1:0] in_symbol = '0;
    logic                in_finish = 1'b0;
    logic                out_ready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [LIMIT_W-1:0]  cfg_data  = '0;
    logic                in_ready;
    logic                out_valid;
    logic                cfg_ready;
    logic [VW-1:0]       out_top;
    logic [DEPTH_W-1:0]  out_depth;
    logic [STATUS_W-1:0] out_status;
    logic                out_answer;

    longint   shadow_stack [DEPTH];
    int       shadow_held  = 0;
    int       shadow_limit = int'(LIMIT_RESET);
    t_outcome predicted_outcomes [$];
    t_outcome head_outcome;
    int       status_seen [8];
    int       errors        = 0;
    int       beats_checked = 0;
    int       scored_items  = 0;
    int       limits_used   = 0;
    int       idle_cycles   = 0;
    int       calm_left     = 0;

    postfix_stack_evaluator_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_symbol       (in_symbol),
        .i_finish       (in_finish),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_top_value    (out_top),
        .o_stack_depth  (out_depth),
        .o_status       (out_status),
        .o_answer_valid (out_answer),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic bit is_digit(input logic [SYMBOL_W-1:0] sym);
        return sym >= CH_ZERO && sym <= CH_NINE;
    endfunction

    function automatic bit is_operator(input logic [SYMBOL_W-1:0] sym);
        return sym inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    endfunction

    function automatic int stack_cap();
        return shadow_limit < DEPTH ? shadow_limit : DEPTH;
    endfunction

    function automatic longint saturate(input t_wide r, inout t_status st);
        t_wide hi_lim;
        t_wide lo_lim;
        hi_lim = VAL_MAX;
        lo_lim = VAL_MIN;
        if (r > hi_lim) begin
            st = ST_SATURATED;
            return VAL_MAX;
        end
        if (r < lo_lim) begin
            st = ST_SATURATED;
            return VAL_MIN;
        end
        return longint'(r);
    endfunction

    function automatic longint scaled_product(input longint a, input longint b,
                                              inout t_status st);
        t_wide wa;
        t_wide wb;
        t_wide prod;
        t_wide mag;
        wa   = a;
        wb   = b;
        prod = wa * wb;
        mag  = prod < 0 ? -prod : prod;
        mag  = mag >> FB;
        return saturate(prod < 0 ? -mag : mag, st);
    endfunction

    function automatic longint scaled_quotient(input longint a, input longint b,
                                               inout t_status st);
        t_wide na;
        t_wide nb;
        t_wide quo;
        bit    neg;
        if (b == 0) begin
            st = ST_DIV_ZERO;
            return a > 0 ? VAL_MAX : (a < 0 ? VAL_MIN : 64'sd0);
        end
        neg = (a < 0) != (b < 0);
        na  = a;
        nb  = b;
        if (na < 0) na = -na;
        if (nb < 0) nb = -nb;
        quo = (na << FB) / nb;
        return saturate(neg ? -quo : quo, st);
    endfunction

    function automatic void push_shadow(input longint v, inout t_status st);
        if (shadow_held >= stack_cap()) begin
            st = ST_PUSH_FULL;
        end else begin
            shadow_stack[shadow_held] = v;
            shadow_held++;
        end
    endfunction

    function automatic t_outcome evaluate_symbol(input logic [SYMBOL_W-1:0] sym,
                                                 input logic fin);
        t_outcome res;
        t_status  st;
        longint   first;
        longint   second;
        longint   r;
        longint   top;
        t_wide    wf;
        t_wide    ws;
        st         = ST_OK;
        top        = 0;
        res.answer = 1'b0;
        if (fin) begin
            if (shadow_held == 0) begin
                st = ST_FINISH_EMPTY;
            end else begin
                top         = shadow_stack[shadow_held-1];
                res.answer  = 1'b1;
                shadow_held = 0;
            end
        end else begin
            if (is_digit(sym)) begin
                r = sym - CH_ZERO;
                push_shadow(r << FB, st);
            end else if (is_operator(sym)) begin
                if (shadow_held < 2) begin
                    st = ST_MISSING;
                end else begin
                    second = shadow_stack[shadow_held-1];
                    first  = shadow_stack[shadow_held-2];
                    shadow_held -= 2;
                    wf = first;
                    ws = second;
                    case (sym)
                        CH_PLUS:  r = saturate(wf + ws, st);
                        CH_MINUS: r = saturate(wf - ws, st);
                        CH_STAR:  r = scaled_product(first, second, st);
                        default:  r = scaled_quotient(first, second, st);
                    endcase
                    push_shadow(r, st);
                end
            end
            if (shadow_held > 0) top = shadow_stack[shadow_held-1];
        end
        res.top    = top[VW-1:0];
        res.depth  = shadow_held[DEPTH_W-1:0];
        res.status = st;
        status_seen[int'(st)]++;
        return res;
    endfunction

    function automatic int draw_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [SYMBOL_W-1:0] random_digit(input bit grow);
        if (grow || $urandom_range(0, 3) == 0) return CH_NINE - SYMBOL_W'($urandom_range(0, 2));
        return CH_ZERO + SYMBOL_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [SYMBOL_W-1:0] random_operator(input bit grow);
        if (grow && $urandom_range(0, 3) != 0) return CH_STAR;
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [SYMBOL_W-1:0] ignored_symbol();
        logic [SYMBOL_W-1:0] s;
        do s = SYMBOL_W'($urandom); while (is_digit(s) || is_operator(s));
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= 100)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input logic fin);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_symbol <= sym;
        in_finish <= fin;
        do @(posedge clk); while (!in_ready);
        predicted_outcomes.push_back(evaluate_symbol(sym, fin));
        if (fin || is_digit(sym) || is_operator(sym)) scored_items++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_outcomes.size() != 0) @(posedge clk);
    endtask

    task automatic write_limit(input int lim);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lim[LIMIT_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        shadow_limit = lim;
        limits_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_stack();
        send_symbol(CH_NINE, 1'b1);
        send_symbol(CH_PLUS, 1'b0);
        send_symbol(8'h41, 1'b0);
    endtask

    task automatic test_single_operand();
        send_symbol(CH_ZERO, 1'b0);
        send_symbol(CH_STAR, 1'b0);
        send_symbol(CH_NINE, 1'b0);
        send_symbol(CH_PLUS, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h00, 1'b1);
    endtask

    task automatic test_divide_by_zero();
        send_symbol(CH_NINE, 1'b0);
        send_symbol(CH_ZERO, 1'b0);
        send_symbol(CH_SLASH, 1'b0);
        send_symbol(CH_ZERO, 1'b0);
        send_symbol(CH_ZERO, 1'b0);
        send_symbol(CH_SLASH, 1'b0);
        send_symbol(CH_MINUS, 1'b0);
        send_symbol(CH_ZERO, 1'b0);
        send_symbol(CH_NINE, 1'b0);
        send_symbol(CH_MINUS, 1'b0);
        send_symbol(CH_ZERO, 1'b0);
        send_symbol(CH_SLASH, 1'b0);
        send_symbol(CH_STAR, 1'b0);
        send_symbol(CH_SLASH, 1'b1);
    endtask

    task automatic test_lowered_limit();
        int k;
        for (k = 1; k <= 5; k++) send_symbol(CH_ZERO + SYMBOL_W'(k), 1'b0);
        write_limit(2);
        send_symbol(CH_PLUS, 1'b0);
        send_symbol(CH_NINE, 1'b0);
        send_symbol(CH_STAR, 1'b1);
    endtask

    task automatic run_expression(input bit grow);
        int wanted;
        int pushes;
        bit can_push;
        bit can_reduce;
        wanted = grow ? $urandom_range(4, 16) : $urandom_range(1, 2 * stack_cap() + 2);
        pushes = 0;
        forever begin
            can_push   = pushes < wanted && shadow_held < stack_cap();
            can_reduce = shadow_held >= 2;
            if (!can_push && !can_reduce) break;
            if ($urandom_range(0, 15) == 0) begin
                send_symbol(ignored_symbol(), 1'b0);
            end else if (can_push && (!can_reduce || $urandom_range(0, grow ? 3 : 1) == 0)) begin
                send_symbol(random_digit(grow), 1'b0);
                pushes++;
            end else begin
                send_symbol(random_operator(grow), 1'b0);
            end
        end
        send_symbol(SYMBOL_W'($urandom), 1'b1);
    endtask

    task automatic run_broken_sequence();
        int count;
        case ($urandom_range(0, 2))
            0: begin
                repeat ($urandom_range(1, 3)) send_symbol(random_operator(1'b0), 1'b0);
            end
            1: begin
                count = stack_cap() - shadow_held + $urandom_range(1, 2);
                repeat (count) send_symbol(random_digit(1'b0), 1'b0);
            end
            default: begin
                repeat ($urandom_range(1, 2)) send_symbol(SYMBOL_W'($urandom), 1'b1);
            end
        endcase
    endtask

    task automatic test_random_expressions();
        int phase;
        int lim;
        int goal;
        int roll;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0, PHASES - 1: lim = DEPTH;
                1:             lim = 1;
                default:       lim = $urandom_range(1, DEPTH);
            endcase
            write_limit(lim);
            goal = scored_items + RANDOM_ITEMS / PHASES;
            while (scored_items < goal) begin
                roll = $urandom_range(0, 99);
                if (roll < 85)
                    run_expression(roll < 20);
                else if (roll < 92)
                    send_symbol(SYMBOL_W'($urandom), 1'($urandom_range(0, 1)));
                else
                    run_broken_sequence();
            end
        end
    endtask

    initial begin : result_sink
        int stall;
        forever begin
            stall = draw_gap();
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && rst_n));
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (predicted_outcomes.size() == 0) begin
                report_mismatch("beat with nothing pending", 64'(out_top), 64'd0);
            end else begin
                head_outcome = predicted_outcomes.pop_front();
                if (out_top !== head_outcome.top)
                    report_mismatch("top_value", 64'(out_top), 64'(head_outcome.top));
                if (out_depth !== head_outcome.depth)
                    report_mismatch("stack_depth", 64'(out_depth), 64'(head_outcome.depth));
                if (out_status !== head_outcome.status)
                    report_mismatch("status", 64'(out_status), 64'(head_outcome.status));
                if (out_answer !== head_outcome.answer)
                    report_mismatch("answer_valid", 64'(out_answer), 64'(head_outcome.answer));
                beats_checked++;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("stalled for %0d cycles with %0d beats pending",
                         idle_cycles, predicted_outcomes.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_stack();
        test_single_operand();
        drain_results();
        test_divide_by_zero();
        test_lowered_limit();
        test_random_expressions();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("checked %0d result beats from %0d evaluated symbols over %0d limit writes",
                 beats_checked, scored_items, limits_used);
        $display("ok %0d, full %0d, missing %0d, div0 %0d, saturated %0d, empty finish %0d",
                 status_seen[ST_OK], status_seen[ST_PUSH_FULL], status_seen[ST_MISSING],
                 status_seen[ST_DIV_ZERO], status_seen[ST_SATURATED],
                 status_seen[ST_FINISH_EMPTY]);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
